// File: rtl/core/c8alu_pkg.sv
// Package: operation codes, flag positions and item types of the 8-bit CPU ALU.
package c8alu_pkg;

  // Operation kinds; codes 24..31 are no-ops.
  typedef enum logic [4:0] {
    K_ADC = 5'd0,
    K_SBC = 5'd1,
    K_AND = 5'd2,
    K_ORA = 5'd3,
    K_EOR = 5'd4,
    K_BIT = 5'd5,
    K_ASL = 5'd6,
    K_LSR = 5'd7,
    K_ROL = 5'd8,
    K_ROR = 5'd9,
    K_CMP = 5'd10,
    K_INC = 5'd11,
    K_DEC = 5'd12,
    K_ANC = 5'd13,
    K_ALR = 5'd14,
    K_ARR = 5'd15,
    K_SLO = 5'd16,
    K_RLA = 5'd17,
    K_SRE = 5'd18,
    K_RRA = 5'd19,
    K_DCP = 5'd20,
    K_ISC = 5'd21,
    K_SBX = 5'd22,
    K_XAA = 5'd23
  } kind_t;

  localparam int unsigned FLAG_C = 0;
  localparam int unsigned FLAG_Z = 1;
  localparam int unsigned FLAG_V = 6;
  localparam int unsigned FLAG_N = 7;

  localparam logic [7:0] XAA_MAGIC = 8'hEE;

  typedef struct packed {
    logic [4:0] kind;
    logic [7:0] acc_in;
    logic [7:0] x_in;
    logic [7:0] operand;
    logic [7:0] compare_reg;
    logic [7:0] status_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] acc_out;
    logic [7:0] x_out;
    logic [7:0] mem_out;
    logic [7:0] status_out;
  } out_item_t;

endpackage

// File: rtl/core/c8alu_if.sv
// Interfaces: valid/ready channels for ALU operations and ALU results.
interface c8alu_in_if;
  logic                 valid;
  logic                 ready;
  c8alu_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface c8alu_out_if;
  logic                 valid;
  logic                 ready;
  c8alu_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/cpu8_alu_with_flags.sv
// Top level: 8-bit CPU ALU (binary mode) with flag update, two register stages.
//
// Usage:
//   in_ch  carries one operation per transfer: kind, A, X, operand, compare
//          register and status byte. out_ch carries the new A, new X, the
//          write-back byte and the new status byte, one result per operation.
//   Path: an operation transfers into the input register; its result is
//   then loaded into the result register, which holds it until taken.
//   Throughput: one operation per cycle while out_ch takes results; the ALU
//   logic between the two registers is a single pass (one 8-bit adder, one
//   8-bit comparator, shifts and logic), so the stages stream back to back.
//   Stall: when out_ch.ready is low the result register holds; the input
//   register still takes a new operation if it is empty, so up to two
//   operations sit inside. in_ch.ready drops only when both are full and
//   the sink stalls.
//   Reset: rst_n low (synchronous) empties both stages; nothing else is kept.
//   Only C, Z, V and N of the status byte change; bits 5..2 pass through.
module cpu8_alu_with_flags (
  input  logic                clk,
  input  logic                rst_n,
  c8alu_in_if.sink            in_ch,
  c8alu_out_if.source         out_ch
);

  // ---- pipeline control ----
  logic                 in_vld_r;
  c8alu_pkg::in_item_t  in_item_r;
  logic                 out_vld_r;
  c8alu_pkg::out_item_t res_r;
  c8alu_pkg::out_item_t res_nxt;

  logic adv_out;   // result register loads this cycle
  logic adv_in;    // input register loads this cycle

  assign adv_out     = in_vld_r & (~out_vld_r | out_ch.ready);
  assign in_ch.ready = ~in_vld_r | adv_out;
  assign adv_in      = in_ch.valid & in_ch.ready;

  assign out_ch.valid = out_vld_r;
  assign out_ch.data  = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        in_vld_r <= in_ch.valid;
      end
      if (~out_vld_r | out_ch.ready) begin
        out_vld_r <= in_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_in) begin
      in_item_r <= in_ch.data;
    end
    if (adv_out) begin
      res_r <= res_nxt;
    end
  end

  // ---- ALU datapath ----
  logic [7:0] a, xr, op, st;
  logic       c_old;

  // shift / rotate / inc / dec results of the operand
  logic [7:0] op_asl, op_lsr, op_rol, op_ror, op_inc, op_dec;
  // logic results against A
  logic [7:0] a_and, a_ora, a_eor;

  // shared adder: sum = A + add_b + add_ci
  logic [7:0] add_b;
  logic       add_ci;
  logic [8:0] add_sum;
  logic       add_v;

  // shared comparator: cmp_reg - cmp_m
  logic [7:0] cmp_reg, cmp_m;
  logic [8:0] cmp_diff;

  logic [7:0] t_ax;     // A AND operand
  logic [7:0] arr_r;
  logic [7:0] acc_nxt, x_nxt, mem_nxt;
  logic       c_nxt, z_nxt, v_nxt, n_nxt;

  assign a     = in_item_r.acc_in;
  assign xr    = in_item_r.x_in;
  assign op    = in_item_r.operand;
  assign st    = in_item_r.status_in;
  assign c_old = st[c8alu_pkg::FLAG_C];

  assign op_asl = {op[6:0], 1'b0};
  assign op_lsr = {1'b0, op[7:1]};
  assign op_rol = {op[6:0], c_old};
  assign op_ror = {c_old, op[7:1]};
  assign op_inc = op + 8'd1;
  assign op_dec = op - 8'd1;

  assign a_and = a & op;
  assign a_ora = a | op;
  assign a_eor = a ^ op;
  assign t_ax  = a_and;
  assign arr_r = {c_old, t_ax[7:1]};

  // Adder operand select: SBC adds the inverted byte, ISC the inverted
  // incremented byte; RRA adds the rotated byte with carry taken from the rotate.
  always_comb begin
    add_b  = op;
    add_ci = c_old;
    unique case (in_item_r.kind)
      c8alu_pkg::K_SBC: add_b = ~op;
      c8alu_pkg::K_RRA: begin
        add_b  = op_ror;
        add_ci = op[0];
      end
      c8alu_pkg::K_ISC: add_b = ~op_inc;
      default: add_b = op;
    endcase
  end

  assign add_sum = {1'b0, a} + {1'b0, add_b} + {8'd0, add_ci};
  assign add_v   = ~(a[7] ^ add_b[7]) & (a[7] ^ add_sum[7]);

  // Comparator operand select: CMP uses the compare register, DCP compares
  // A with the decremented byte, SBX compares A AND X with the operand.
  always_comb begin
    cmp_reg = in_item_r.compare_reg;
    cmp_m   = op;
    unique case (in_item_r.kind)
      c8alu_pkg::K_DCP: begin
        cmp_reg = a;
        cmp_m   = op_dec;
      end
      c8alu_pkg::K_SBX: cmp_reg = a & xr;
      default: cmp_reg = in_item_r.compare_reg;
    endcase
  end

  assign cmp_diff = {1'b0, cmp_reg} - {1'b0, cmp_m};

  always_comb begin
    acc_nxt = a;
    x_nxt   = xr;
    mem_nxt = op;
    c_nxt   = st[c8alu_pkg::FLAG_C];
    z_nxt   = st[c8alu_pkg::FLAG_Z];
    v_nxt   = st[c8alu_pkg::FLAG_V];
    n_nxt   = st[c8alu_pkg::FLAG_N];
    unique case (in_item_r.kind)
      c8alu_pkg::K_ADC, c8alu_pkg::K_SBC, c8alu_pkg::K_ISC: begin
        acc_nxt = add_sum[7:0];
        c_nxt   = add_sum[8];
        v_nxt   = add_v;
        z_nxt   = (add_sum[7:0] == 8'd0);
        n_nxt   = add_sum[7];
        if (in_item_r.kind == c8alu_pkg::K_ISC) begin
          mem_nxt = op_inc;
        end
      end
      c8alu_pkg::K_AND: begin
        acc_nxt = a_and;
        z_nxt   = (a_and == 8'd0);
        n_nxt   = a_and[7];
      end
      c8alu_pkg::K_ORA: begin
        acc_nxt = a_ora;
        z_nxt   = (a_ora == 8'd0);
        n_nxt   = a_ora[7];
      end
      c8alu_pkg::K_EOR: begin
        acc_nxt = a_eor;
        z_nxt   = (a_eor == 8'd0);
        n_nxt   = a_eor[7];
      end
      c8alu_pkg::K_BIT: begin
        z_nxt = (a_and == 8'd0);
        v_nxt = op[6];
        n_nxt = op[7];
      end
      c8alu_pkg::K_ASL: begin
        mem_nxt = op_asl;
        c_nxt   = op[7];
        z_nxt   = (op_asl == 8'd0);
        n_nxt   = op_asl[7];
      end
      c8alu_pkg::K_LSR: begin
        mem_nxt = op_lsr;
        c_nxt   = op[0];
        z_nxt   = (op_lsr == 8'd0);
        n_nxt   = 1'b0;
      end
      c8alu_pkg::K_ROL: begin
        mem_nxt = op_rol;
        c_nxt   = op[7];
        z_nxt   = (op_rol == 8'd0);
        n_nxt   = op_rol[7];
      end
      c8alu_pkg::K_ROR: begin
        mem_nxt = op_ror;
        c_nxt   = op[0];
        z_nxt   = (op_ror == 8'd0);
        n_nxt   = op_ror[7];
      end
      c8alu_pkg::K_CMP, c8alu_pkg::K_DCP, c8alu_pkg::K_SBX: begin
        c_nxt = ~cmp_diff[8];
        z_nxt = (cmp_reg == cmp_m);
        n_nxt = cmp_diff[7];
        if (in_item_r.kind == c8alu_pkg::K_DCP) begin
          mem_nxt = op_dec;
        end
        if (in_item_r.kind == c8alu_pkg::K_SBX) begin
          x_nxt = cmp_diff[7:0];
        end
      end
      c8alu_pkg::K_INC: begin
        mem_nxt = op_inc;
        z_nxt   = (op_inc == 8'd0);
        n_nxt   = op_inc[7];
      end
      c8alu_pkg::K_DEC: begin
        mem_nxt = op_dec;
        z_nxt   = (op_dec == 8'd0);
        n_nxt   = op_dec[7];
      end
      c8alu_pkg::K_ANC: begin
        acc_nxt = a_and;
        z_nxt   = (a_and == 8'd0);
        n_nxt   = a_and[7];
        c_nxt   = a_and[7];
      end
      c8alu_pkg::K_ALR: begin
        acc_nxt = {1'b0, t_ax[7:1]};
        c_nxt   = t_ax[0];
        z_nxt   = (t_ax[7:1] == 7'd0);
        n_nxt   = 1'b0;
      end
      c8alu_pkg::K_ARR: begin
        acc_nxt = arr_r;
        z_nxt   = (arr_r == 8'd0);
        n_nxt   = arr_r[7];
        c_nxt   = arr_r[6];
        v_nxt   = arr_r[6] ^ arr_r[5];
      end
      c8alu_pkg::K_SLO: begin
        mem_nxt = op_asl;
        acc_nxt = a | op_asl;
        c_nxt   = op[7];
        z_nxt   = ((a | op_asl) == 8'd0);
        n_nxt   = a[7] | op_asl[7];
      end
      c8alu_pkg::K_RLA: begin
        mem_nxt = op_rol;
        acc_nxt = a & op_rol;
        c_nxt   = op[7];
        z_nxt   = ((a & op_rol) == 8'd0);
        n_nxt   = a[7] & op_rol[7];
      end
      c8alu_pkg::K_SRE: begin
        mem_nxt = op_lsr;
        acc_nxt = a ^ op_lsr;
        c_nxt   = op[0];
        z_nxt   = ((a ^ op_lsr) == 8'd0);
        n_nxt   = a[7];
      end
      c8alu_pkg::K_RRA: begin
        mem_nxt = op_ror;
        acc_nxt = add_sum[7:0];
        c_nxt   = add_sum[8];
        v_nxt   = add_v;
        z_nxt   = (add_sum[7:0] == 8'd0);
        n_nxt   = add_sum[7];
      end
      c8alu_pkg::K_XAA: begin
        acc_nxt = (a | c8alu_pkg::XAA_MAGIC) & xr & op;
        z_nxt   = (((a | c8alu_pkg::XAA_MAGIC) & xr & op) == 8'd0);
        // the magic constant sets bit 7, so A drops out of N
        n_nxt   = xr[7] & op[7];
      end
      default: begin
        // unused codes: everything passes through
        acc_nxt = a;
      end
    endcase
  end

  always_comb begin
    res_nxt.acc_out    = acc_nxt;
    res_nxt.x_out      = x_nxt;
    res_nxt.mem_out    = mem_nxt;
    res_nxt.status_out = {n_nxt, v_nxt, st[5:2], z_nxt, c_nxt};
  end

  // ---- assertions ----
  // status bits 5..2 never change
  a_status_pass: assert property (@(posedge clk) disable iff (!rst_n)
    adv_out |=> (res_r.status_out[5:2] == $past(in_item_r.status_in[5:2])))
    else $error("status bits 5..2 altered");

  // X changes only for SBX
  a_x_only_sbx: assert property (@(posedge clk) disable iff (!rst_n)
    (adv_out && (in_item_r.kind != c8alu_pkg::K_SBX))
      |=> (res_r.x_out == $past(in_item_r.x_in)))
    else $error("X modified by a kind other than SBX");

  // unused codes leave every field as it came in
  a_unused_noop: assert property (@(posedge clk) disable iff (!rst_n)
    (adv_out && (in_item_r.kind[4:3] == 2'b11))
      |=> ((res_r.acc_out == $past(in_item_r.acc_in))
        && (res_r.mem_out == $past(in_item_r.operand))
        && (res_r.status_out == $past(in_item_r.status_in))))
    else $error("unused kind changed an output");

  // a result only appears after an operation sat in the input register
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(in_vld_r))
    else $error("result valid without a prior operation");

  // input register is never overwritten while its operation is still held
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !adv_out) |-> !adv_in)
    else $error("input register overwritten while holding an operation");

endmodule

// File: bench/cpu8_alu_with_flags_tb.sv
// Testbench for cpu8_alu_with_flags: directed and random ALU operations checked against a local flag model.
module cpu8_alu_with_flags_tb;

  // Generous cap on the run length, in cycles.
  localparam int CYCLE_LIMIT   = 100000;
  localparam int RANDOM_OPS    = 850;
  localparam int DRAIN_CYCLES  = 8;
  // Codes above XAA are no-ops; the top one is used in the directed part.
  localparam int          KIND_FIRST_SPARE = int'(c8alu_pkg::K_XAA) + 1;
  localparam logic [4:0]  KIND_LAST_SPARE  = 5'd31;
  // Status bits 5..2 must pass through untouched; this pattern lights them all.
  localparam logic [7:0]  MID_BITS = 8'h3C;

  // Scoreboard: predicts the ALU result of every accepted operation and
  // checks results in order against the queue of predictions.
  class alu_result_board;
    c8alu_pkg::out_item_t outcomes_due[$];
    int          errors;
    int          results_checked;
    bit [31:0]   kinds_seen;

    function void set_zn(inout logic [7:0] st, input logic [7:0] v);
      st[c8alu_pkg::FLAG_Z] = (v == 8'h00);
      st[c8alu_pkg::FLAG_N] = v[7];
    endfunction

    // Binary add with carry in, as used by ADC, SBC, RRA and ISC.
    function void add_with_carry(inout logic [7:0] a, inout logic [7:0] st,
                                 input logic [7:0] m);
      logic [8:0] sum;
      sum = {1'b0, a} + {1'b0, m} + {8'd0, st[c8alu_pkg::FLAG_C]};
      st[c8alu_pkg::FLAG_V] = ~(a[7] ^ m[7]) & (a[7] ^ sum[7]);
      st[c8alu_pkg::FLAG_C] = sum[8];
      a = sum[7:0];
      set_zn(st, a);
    endfunction

    // Compare leaves V alone; C means no borrow.
    function void compare_flags(inout logic [7:0] st, input logic [7:0] r,
                                input logic [7:0] m);
      logic [7:0] diff;
      diff = r - m;
      st[c8alu_pkg::FLAG_C] = (r >= m);
      st[c8alu_pkg::FLAG_Z] = (r == m);
      st[c8alu_pkg::FLAG_N] = diff[7];
    endfunction

    function c8alu_pkg::out_item_t alu_outcome(c8alu_pkg::in_item_t it);
      c8alu_pkg::out_item_t res;
      logic [7:0] a, x, m, op, st, t;
      logic       c_old;
      a     = it.acc_in;
      x     = it.x_in;
      op    = it.operand;
      m     = it.operand;
      st    = it.status_in;
      c_old = st[c8alu_pkg::FLAG_C];
      case (it.kind)
        c8alu_pkg::K_ADC: add_with_carry(a, st, op);
        c8alu_pkg::K_SBC: add_with_carry(a, st, ~op);
        c8alu_pkg::K_AND: begin a = a & op; set_zn(st, a); end
        c8alu_pkg::K_ORA: begin a = a | op; set_zn(st, a); end
        c8alu_pkg::K_EOR: begin a = a ^ op; set_zn(st, a); end
        c8alu_pkg::K_BIT: begin
          st[c8alu_pkg::FLAG_Z] = ((a & op) == 8'h00);
          st[c8alu_pkg::FLAG_V] = op[6];
          st[c8alu_pkg::FLAG_N] = op[7];
        end
        c8alu_pkg::K_ASL, c8alu_pkg::K_SLO: begin
          m = {op[6:0], 1'b0};
          st[c8alu_pkg::FLAG_C] = op[7];
          set_zn(st, m);
          if (it.kind == c8alu_pkg::K_SLO) begin a = a | m; set_zn(st, a); end
        end
        c8alu_pkg::K_LSR, c8alu_pkg::K_SRE: begin
          m = {1'b0, op[7:1]};
          st[c8alu_pkg::FLAG_C] = op[0];
          set_zn(st, m);
          if (it.kind == c8alu_pkg::K_SRE) begin a = a ^ m; set_zn(st, a); end
        end
        c8alu_pkg::K_ROL, c8alu_pkg::K_RLA: begin
          m = {op[6:0], c_old};
          st[c8alu_pkg::FLAG_C] = op[7];
          set_zn(st, m);
          if (it.kind == c8alu_pkg::K_RLA) begin a = a & m; set_zn(st, a); end
        end
        c8alu_pkg::K_ROR, c8alu_pkg::K_RRA: begin
          m = {c_old, op[7:1]};
          st[c8alu_pkg::FLAG_C] = op[0];
          set_zn(st, m);
          // RRA adds with the carry just shifted out
          if (it.kind == c8alu_pkg::K_RRA) add_with_carry(a, st, m);
        end
        c8alu_pkg::K_CMP: compare_flags(st, it.compare_reg, op);
        c8alu_pkg::K_INC: begin m = op + 8'd1; set_zn(st, m); end
        c8alu_pkg::K_DEC: begin m = op - 8'd1; set_zn(st, m); end
        c8alu_pkg::K_ANC: begin
          a = a & op;
          set_zn(st, a);
          st[c8alu_pkg::FLAG_C] = a[7];
        end
        c8alu_pkg::K_ALR: begin
          t = a & op;
          st[c8alu_pkg::FLAG_C] = t[0];
          a = {1'b0, t[7:1]};
          set_zn(st, a);
        end
        c8alu_pkg::K_ARR: begin
          t = a & op;
          a = {c_old, t[7:1]};
          set_zn(st, a);
          st[c8alu_pkg::FLAG_C] = a[6];
          st[c8alu_pkg::FLAG_V] = a[6] ^ a[5];
        end
        c8alu_pkg::K_DCP: begin
          m = op - 8'd1;
          compare_flags(st, a, m);
        end
        c8alu_pkg::K_ISC: begin
          m = op + 8'd1;
          add_with_carry(a, st, ~m);
        end
        c8alu_pkg::K_SBX: begin
          t = a & x;
          compare_flags(st, t, op);
          x = t - op;
        end
        c8alu_pkg::K_XAA: begin
          a = (a | c8alu_pkg::XAA_MAGIC) & x & op;
          set_zn(st, a);
        end
        default: ;
      endcase
      res.acc_out    = a;
      res.x_out      = x;
      res.mem_out    = m;
      res.status_out = st;
      return res;
    endfunction

    function void note_op(c8alu_pkg::in_item_t it);
      kinds_seen[it.kind] = 1'b1;
      outcomes_due.push_back(alu_outcome(it));
    endfunction

    function void check_result(c8alu_pkg::out_item_t got);
      c8alu_pkg::out_item_t want;
      if (outcomes_due.size() == 0) begin
        $error("result transfer with no operation outstanding: %h", got);
        errors++;
        return;
      end
      want = outcomes_due.pop_front();
      results_checked++;
      if (got.acc_out !== want.acc_out) begin
        $error("acc_out: expected %02h, actual %02h", want.acc_out, got.acc_out);
        errors++;
      end
      if (got.x_out !== want.x_out) begin
        $error("x_out: expected %02h, actual %02h", want.x_out, got.x_out);
        errors++;
      end
      if (got.mem_out !== want.mem_out) begin
        $error("mem_out: expected %02h, actual %02h", want.mem_out, got.mem_out);
        errors++;
      end
      if (got.status_out !== want.status_out) begin
        $error("status_out: expected %02h, actual %02h",
               want.status_out, got.status_out);
        errors++;
      end
    endfunction

    function int pending();
      return outcomes_due.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   cycle_count;
  bit   send_burst;   // sender runs without gaps while set
  bit   take_burst;   // result side keeps ready high while set

  alu_result_board board = new();

  c8alu_in_if  in_ch();
  c8alu_out_if out_ch();

  cpu8_alu_with_flags DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Monitor: both channels are sampled at the clock edge, before any of
  // this edge's updates land, so order within the time step does not matter.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) board.note_op(in_ch.data);
    if (rst_n && out_ch.valid && out_ch.ready) board.check_result(out_ch.data);
  end

  // Idle cycles before the next transfer; zero throughout a burst.
  function automatic int draw_idle(bit burst);
    return burst ? 0 : int'($urandom_range(0, 5));
  endfunction

  // Operand bytes lean on the corner values that flip carry, zero and sign.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h7F;
      3: return 8'h80;
      default: return 8'($urandom);
    endcase
  endfunction

  // Drive one operation. Called at a clock edge, returns at the edge where
  // the transfer happened; valid stays high into a back-to-back transfer.
  task automatic send_op(input c8alu_pkg::in_item_t it);
    int idle;
    if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
    idle = draw_idle(send_burst);
    if (idle > 0) begin
      in_ch.valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_ch.data  <= it;
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_fields(input logic [4:0] kind, input logic [7:0] a,
                             input logic [7:0] x, input logic [7:0] op,
                             input logic [7:0] creg, input logic [7:0] st);
    c8alu_pkg::in_item_t it;
    it.kind        = kind;
    it.acc_in      = a;
    it.x_in        = x;
    it.operand     = op;
    it.compare_reg = creg;
    it.status_in   = st;
    send_op(it);
  endtask

  // Result side: random stalls between transfers, with ready-high stretches.
  initial begin
    int idle;
    out_ch.ready = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if ($urandom_range(0, 39) == 0) take_burst = !take_burst;
      idle = draw_idle(take_burst);
      if (idle > 0) begin
        out_ch.ready <= 1'b0;
        repeat (idle) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  initial begin
    c8alu_pkg::in_item_t it;
    rst_n       = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: every kind at least once, with the flag corners each one is known for.
    //           kind              A      X      operand CMPreg status
    send_fields(c8alu_pkg::K_ADC, 8'h7F, 8'h00, 8'h01, 8'h00, 8'h00);  // signed overflow
    send_fields(c8alu_pkg::K_ADC, 8'hFF, 8'h00, 8'h01, 8'h00, MID_BITS);  // carry, zero
    send_fields(c8alu_pkg::K_SBC, 8'h80, 8'h00, 8'h01, 8'h00, 8'h01);  // overflow
    send_fields(c8alu_pkg::K_AND, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hC1);
    send_fields(c8alu_pkg::K_ORA, 8'h00, 8'h00, 8'h80, 8'h00, 8'h00);
    send_fields(c8alu_pkg::K_EOR, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF);
    send_fields(c8alu_pkg::K_BIT, 8'h00, 8'h00, 8'hC0, 8'h00, 8'h00);  // Z, V and N
    send_fields(c8alu_pkg::K_ASL, 8'h12, 8'h00, 8'h80, 8'h00, 8'h00);  // carry, zero
    send_fields(c8alu_pkg::K_LSR, 8'h34, 8'h00, 8'h01, 8'h00, 8'h00);
    send_fields(c8alu_pkg::K_ROL, 8'h00, 8'h00, 8'h80, 8'h00, 8'h01);  // C into bit 0
    send_fields(c8alu_pkg::K_ROR, 8'h00, 8'h00, 8'h01, 8'h00, 8'h01);  // C into bit 7
    send_fields(c8alu_pkg::K_CMP, 8'h00, 8'h00, 8'h40, 8'h40, 8'h40);  // equal, V kept
    send_fields(c8alu_pkg::K_INC, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00);  // wraps to zero
    send_fields(c8alu_pkg::K_DEC, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);  // wraps to FF
    send_fields(c8alu_pkg::K_ANC, 8'hFF, 8'h00, 8'h80, 8'h00, 8'h00);
    send_fields(c8alu_pkg::K_ALR, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00);
    send_fields(c8alu_pkg::K_ARR, 8'hFF, 8'h00, 8'h7F, 8'h00, 8'h01);  // V from 6 and 5
    send_fields(c8alu_pkg::K_SLO, 8'h01, 8'h00, 8'h80, 8'h00, 8'h00);
    send_fields(c8alu_pkg::K_RLA, 8'hFF, 8'h00, 8'h7F, 8'h00, 8'h01);
    send_fields(c8alu_pkg::K_SRE, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00);
    send_fields(c8alu_pkg::K_RRA, 8'h7F, 8'h00, 8'h02, 8'h00, 8'h01);  // rotated byte
    send_fields(c8alu_pkg::K_DCP, 8'hFE, 8'h00, 8'hFF, 8'h00, 8'h40);
    send_fields(c8alu_pkg::K_ISC, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h01);
    send_fields(c8alu_pkg::K_SBX, 8'hFF, 8'h0F, 8'h10, 8'h00, 8'h40);  // X written
    send_fields(c8alu_pkg::K_XAA, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00);  // magic shows
    send_fields(KIND_LAST_SPARE, 8'h5A, 8'hA5, 8'h3C, 8'hC3, 8'hFF);  // no-op code

    // Random: mostly real operations, a few no-op codes, corner-heavy bytes.
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if ($urandom_range(0, 19) == 0)
        it.kind = 5'($urandom_range(KIND_FIRST_SPARE, 31));
      else
        it.kind = 5'($urandom_range(0, int'(c8alu_pkg::K_XAA)));
      it.acc_in      = pick_byte();
      it.x_in        = pick_byte();
      it.operand     = pick_byte();
      it.compare_reg = pick_byte();
      it.status_in   = 8'($urandom);
      // Force the equal case of the compares now and then.
      if ($urandom_range(0, 5) == 0) begin
        case (it.kind)
          c8alu_pkg::K_CMP: it.compare_reg = it.operand;
          c8alu_pkg::K_DCP: it.acc_in      = it.operand - 8'd1;
          c8alu_pkg::K_SBX: it.operand     = it.acc_in & it.x_in;
          default: ;
        endcase
      end
      send_op(it);
    end
    in_ch.valid <= 1'b0;

    // Drain, then give a stray extra result time to show up.
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d ALU results; %0d of 32 operation codes exercised",
             board.results_checked, $countones(board.kinds_seen));
    if (board.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
